// File: sv/sha384_pkg.sv
package sha384_pkg;

   localparam int RoundCount = 80;

   typedef logic [63:0] word_type;
   typedef logic [6:0] round_type;

   function automatic word_type round_k(input round_type t);
      word_type k;
      begin
         unique case (t)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
         endcase
         return k;
      end
   endfunction

   function automatic word_type init_h(input logic [2:0] i);
      word_type h;
      begin
         unique case (i)
            3'd0: h = 64'hcbbb9d5dc1059ed8;
            3'd1: h = 64'h629a292a367cd507;
            3'd2: h = 64'h9159015a3070dd17;
            3'd3: h = 64'h152fecd8f70e5939;
            3'd4: h = 64'h67332667ffc00b31;
            3'd5: h = 64'h8eb44a8768581511;
            3'd6: h = 64'hdb0c2e0d64f98fa7;
            default: h = 64'h47b5481dbefa4fa4;
         endcase
         return h;
      end
   endfunction

   // round engine control from the sequencer
   typedef struct packed {
      logic start;  // load working words from chaining words
      logic finish; // fold working words into chaining words
      logic init;   // restore initial chaining words
   } eng_ctl_type;

endpackage

// File: sv/sha384_round.sv
// one sha-512 round per cycle while round_en is high; schedule window and working words live here
module sha384_round (
   input  logic                      clock,
   input  logic                      reset,
   input  sha384_pkg::eng_ctl_type   ctl,
   input  logic                      round_en,
   input  sha384_pkg::round_type     round,
   input  logic [1023:0]             block,
   input  logic [2:0]                rd_index,
   output sha384_pkg::word_type      rd_word
);

   sha384_pkg::word_type h_ff [8];
   sha384_pkg::word_type v_ff [8];
   sha384_pkg::word_type w_ff [16];
   sha384_pkg::word_type w_cur, t1, t2, x2, x15, s0, s1, e_s, a_s, ch, mj;
   logic [3:0] t4;

   assign t4  = round[3:0];
   assign x2  = w_ff[4'(t4 - 4'd2)];
   assign x15 = w_ff[4'(t4 - 4'd15)];
   assign s1  = {x2[18:0], x2[63:19]} ^ {x2[60:0], x2[63:61]} ^ (x2 >> 6);
   assign s0  = {x15[0], x15[63:1]} ^ {x15[7:0], x15[63:8]} ^ (x15 >> 7);

   always_comb begin
      if (round < 7'd16) begin
         w_cur = block[1023 - 64*t4 -: 64];
      end else begin
         w_cur = s1 + w_ff[4'(t4 - 4'd7)] + s0 + w_ff[t4];
      end
   end

   assign e_s = {v_ff[4][13:0], v_ff[4][63:14]} ^ {v_ff[4][17:0], v_ff[4][63:18]}
              ^ {v_ff[4][40:0], v_ff[4][63:41]};
   assign a_s = {v_ff[0][27:0], v_ff[0][63:28]} ^ {v_ff[0][33:0], v_ff[0][63:34]}
              ^ {v_ff[0][38:0], v_ff[0][63:39]};
   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign mj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + e_s + ch + sha384_pkg::round_k(round) + w_cur;
   assign t2  = a_s + mj;

   always_ff @(posedge clock) begin
      if (round_en) begin
         w_ff[t4] <= w_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha384_pkg::init_h(3'(i));
            v_ff[i] <= '0;
         end
      end else if (ctl.start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (ctl.finish) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end else if (round_en) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   assign rd_word = h_ff[rd_index];

`ifndef NO_ASSERTIONS
   a_start_finish_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.start && ctl.finish)) else $error("start and finish together");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_en |-> round < 7'(sha384_pkg::RoundCount)) else $error("round out of range");
   a_no_round_on_start: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !round_en) else $error("round during load");
`endif

endmodule

// File: sv/sha384_stream_hash_core.sv
// streaming sha-384 hash core
// input channel (req_): one transaction per message byte slot; req_byte_present
//   marks req_data_byte as a message byte, req_end_of_message closes the message
//   after that byte (a transaction with neither is ignored)
// output channel (rsp_): six transactions per message, digest word 0 first,
//   rsp_last_word on word 5
// a byte that does not fill the block is only stored; a byte that completes a
//   128-byte block runs the shared round unit for 80 rounds plus a load and a
//   fold step, and req_ready stays low until the block is folded
// closing a message pads and compresses one or two more blocks, then offers the
//   six words once the last block is folded (two blocks when the padding or the
//   closing byte needs a second block)
// req_ready stays low until the last word is taken
// a stalled receiver simply holds the current word on rsp_ with valid high
// reset (synchronous, active high) restores initial chaining values and empties
//   the block and byte count; after the digest the core returns to that state
module sha384_stream_hash_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
   } state_type;

   state_type                state_ff;
   logic [1023:0]            blk_ff;
   logic [6:0]               fill_ff;
   logic [60:0]              count_ff;
   sha384_pkg::round_type    round_ff;
   logic                     closing_ff;  // message closed, padding outstanding
   logic                     final_ff;    // block in flight carries the length
   logic [2:0]               widx_ff;
   sha384_pkg::eng_ctl_type  ctl;
   logic                     round_en;
   logic                     accept;
   logic [6:0]               fill_in;
   logic [60:0]              count_in;
   logic [1023:0]            blk_in;
   logic [1023:0]            pad_blk;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_word_index = widx_ff;
   assign rsp_last_word  = (widx_ff == 3'd5);
   assign round_en  = (state_ff == ST_ROUND);
   assign ctl.start  = (state_ff == ST_LOAD);
   assign ctl.finish = (state_ff == ST_FOLD);
   assign ctl.init   = (state_ff == ST_OUT) && rsp_ready && (widx_ff == 3'd5);

   sha384_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .round_en (round_en),
      .round    (round_ff),
      .block    (blk_ff),
      .rd_index (widx_ff),
      .rd_word  (rsp_digest_word)
   );

   // byte insert into block buffer
   always_comb begin
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (req_byte_present) begin
         blk_in[1023 - 8*fill_ff -: 8] = req_data_byte;
         fill_in  = fill_ff + 7'd1;
         count_in = count_ff + 61'd1;
      end
   end

   // 0x80 marker at the fill point, zero beyond, length when it fits
   always_comb begin
      pad_blk = blk_ff;
      for (int i = 0; i < 128; i++) begin
         if (7'(i) == fill_ff) pad_blk[1023 - 8*i -: 8] = 8'h80;
         else if (7'(i) > fill_ff) pad_blk[1023 - 8*i -: 8] = 8'h00;
      end
      if (fill_ff <= 7'd111) begin
         pad_blk[63:0] = {count_ff, 3'b000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         blk_ff     <= '0;
         fill_ff    <= '0;
         count_ff   <= '0;
         round_ff   <= '0;
         closing_ff <= 1'b0;
         final_ff   <= 1'b0;
         widx_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  blk_ff     <= blk_in;
                  fill_ff    <= fill_in;
                  count_ff   <= count_in;
                  closing_ff <= req_end_of_message;
                  if (req_byte_present && fill_in == 7'd0) begin
                     state_ff <= ST_LOAD;
                  end else if (req_end_of_message) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               blk_ff <= pad_blk;
               if (fill_ff <= 7'd111) begin
                  final_ff <= 1'b1;
               end
               closing_ff <= 1'b0;
               state_ff   <= ST_LOAD;
            end
            ST_LOAD: begin
               round_ff <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (round_ff == 7'(sha384_pkg::RoundCount - 1)) begin
                  round_ff <= '0;
                  state_ff <= ST_FOLD;
               end else begin
                  round_ff <= round_ff + 7'd1;
               end
            end
            ST_FOLD: begin
               fill_ff <= '0;
               if (final_ff) begin
                  final_ff <= 1'b0;
                  widx_ff  <= '0;
                  state_ff <= ST_OUT;
               end else if (closing_ff) begin
                  // full block closed the message: pad a fresh block
                  blk_ff   <= '0;
                  state_ff <= ST_PAD;
               end else if (fill_ff != 7'd0) begin
                  // overflow pad block done: length-only block follows
                  blk_ff         <= {960'b0, count_ff, 3'b000};
                  final_ff       <= 1'b1;
                  state_ff       <= ST_LOAD;
               end else begin
                  blk_ff   <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  if (widx_ff == 3'd5) begin
                     widx_ff  <= '0;
                     blk_ff   <= '0;
                     fill_ff  <= '0;
                     count_ff <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     widx_ff <= widx_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_out_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> widx_ff <= 3'd5) else $error("digest index out of range");
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      round_en |-> !req_ready && !rsp_valid) else $error("ready while hashing");
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> state_ff == ST_IDLE)
      else $error("no return to idle after digest");
`endif

endmodule
